// ----- src/tci_pkg.sv -----
`default_nettype none
package tci_pkg;

   localparam int ETA_W = 12;
   localparam int PHI_W = 12;
   localparam int PT_W  = 14;
   localparam int SUM_W = 16;

   // tracks carried by one transaction, one lane each
   localparam int LANES = 3;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ETA_WINDOW     = 2'd0,
      CSR_PHI_WINDOW     = 2'd1,
      CSR_TRACK_PT_MIN   = 2'd2,
      CSR_ISO_THRESHOLD  = 2'd3
   } csr_index_type;

   localparam logic [ETA_W-1:0] ETA_WINDOW_RST    = ETA_W'(256);
   localparam logic [PHI_W-1:0] PHI_WINDOW_RST    = PHI_W'(256);
   localparam logic [PT_W-1:0]  TRACK_PT_MIN_RST  = PT_W'(4);
   localparam logic [SUM_W-1:0] ISO_THRESHOLD_RST = SUM_W'(1000);

   // smallest absolute difference that still counts is one above this
   localparam int DIFF_FLOOR = 1;

   typedef struct packed {
      logic [ETA_W-1:0] eta;
      logic [PHI_W-1:0] phi;
      logic [PT_W-1:0]  pt;
   } track_type;

   typedef struct packed {
      logic [ETA_W-1:0] eta_window;
      logic [PHI_W-1:0] phi_window;
      logic [PT_W-1:0]  track_pt_min;
   } cone_cfg_type;

   // control of the lane stage, seen by the merge
   typedef struct packed {
      logic valid;
      logic last;
   } stage_type;

endpackage
`default_nettype wire

// ----- src/track_cone_isolation.sv -----
`default_nettype none
// Muon track-cone isolation. Each transaction carries the muon eta/phi and
// three tracks; the three tracks are tested in three parallel lanes (wrapped
// signed eta/phi distance inside the window registers and above one, pt above
// track_pt_min) and a merge stage adds the passing pt to a saturating 16-bit
// cone sum. The transaction marked event_last closes the event: one result
// with isolated = 1 when the sum, including that transaction's tracks, is
// below iso_threshold, and the sum is cleared. A transaction is accepted every
// clock while nothing stalls; a transaction passes through one lane register,
// then one merge/result register. Only a closing transaction can stall,
// and only while an earlier result is still waiting on rsp_ready. Write the
// registers only while no event is in progress.
module track_cone_isolation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [tci_pkg::ETA_W-1:0]           req_muon_eta,
   input  wire logic [tci_pkg::PHI_W-1:0]           req_muon_phi,
   input  wire logic [tci_pkg::ETA_W-1:0]           req_track_a_eta,
   input  wire logic [tci_pkg::PHI_W-1:0]           req_track_a_phi,
   input  wire logic [tci_pkg::PT_W-1:0]            req_track_a_pt,
   input  wire logic [tci_pkg::ETA_W-1:0]           req_track_b_eta,
   input  wire logic [tci_pkg::PHI_W-1:0]           req_track_b_phi,
   input  wire logic [tci_pkg::PT_W-1:0]            req_track_b_pt,
   input  wire logic [tci_pkg::ETA_W-1:0]           req_track_c_eta,
   input  wire logic [tci_pkg::PHI_W-1:0]           req_track_c_phi,
   input  wire logic [tci_pkg::PT_W-1:0]            req_track_c_pt,
   input  wire logic                                req_event_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_isolated,
   input  wire logic                                csr_write_en,
   input  wire logic [tci_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tci_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import tci_pkg::*;

   logic [ETA_W-1:0] eta_window_ff;
   logic [PHI_W-1:0] phi_window_ff;
   logic [PT_W-1:0]  track_pt_min_ff;
   logic [SUM_W-1:0] iso_threshold_ff;
   cone_cfg_type     cfg;
   track_type        tracks [LANES];
   logic [SUM_W-1:0] lane_pt [LANES];
   stage_type        stage_ff;
   stage_type        stage_in;
   logic             accept;
   logic             advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eta_window_ff    <= ETA_WINDOW_RST;
         phi_window_ff    <= PHI_WINDOW_RST;
         track_pt_min_ff  <= TRACK_PT_MIN_RST;
         iso_threshold_ff <= ISO_THRESHOLD_RST;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ETA_WINDOW:    eta_window_ff    <= ETA_W'(csr_write_data);
            CSR_PHI_WINDOW:    phi_window_ff    <= PHI_W'(csr_write_data);
            CSR_TRACK_PT_MIN:  track_pt_min_ff  <= PT_W'(csr_write_data);
            CSR_ISO_THRESHOLD: iso_threshold_ff <= SUM_W'(csr_write_data);
            default: ;
         endcase
      end
   end

   assign cfg = '{eta_window: eta_window_ff, phi_window: phi_window_ff,
                  track_pt_min: track_pt_min_ff};

   assign tracks[0] = '{eta: req_track_a_eta, phi: req_track_a_phi, pt: req_track_a_pt};
   assign tracks[1] = '{eta: req_track_b_eta, phi: req_track_b_phi, pt: req_track_b_pt};
   assign tracks[2] = '{eta: req_track_c_eta, phi: req_track_c_phi, pt: req_track_c_pt};

   // take a transaction whenever the lane stage is empty or moving on
   assign req_ready = !stage_ff.valid || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in.valid = 1'b1;
         stage_in.last  = req_event_last;
      end else if (advance) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // one lane per track
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      tci_lane u_lane (
         .clock    (clock),
         .load     (accept),
         .muon_eta (req_muon_eta),
         .muon_phi (req_muon_phi),
         .track    (tracks[g]),
         .cfg      (cfg),
         .lane_pt  (lane_pt[g])
      );
   end

   tci_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage_ff),
      .lane_pt       (lane_pt),
      .iso_threshold (iso_threshold_ff),
      .rsp_ready     (rsp_ready),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_isolated  (rsp_isolated)
   );

endmodule
`default_nettype wire

// ----- src/tci_lane.sv -----
`default_nettype none
module tci_lane (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [tci_pkg::ETA_W-1:0] muon_eta,
   input  wire logic [tci_pkg::PHI_W-1:0] muon_phi,
   input  wire tci_pkg::track_type        track,
   input  wire tci_pkg::cone_cfg_type     cfg,
   output logic [tci_pkg::SUM_W-1:0]      lane_pt
);
   import tci_pkg::*;

   localparam int EXT_W = (PT_W > SUM_W) ? PT_W : SUM_W;

   logic [ETA_W-1:0] deta;
   logic [PHI_W-1:0] dphi;
   logic [ETA_W:0]   abs_deta;
   logic [PHI_W:0]   abs_dphi;
   logic [EXT_W-1:0] pt_ext;
   logic [SUM_W-1:0] pt_sat;
   logic             in_cone;
   logic [SUM_W-1:0] lane_pt_ff;
   logic [SUM_W-1:0] lane_pt_in;

   // wrap differences and take magnitudes as signed values
   always_comb begin
      deta = track.eta - muon_eta;
      dphi = track.phi - muon_phi;
      if (deta[ETA_W-1]) begin
         abs_deta = (ETA_W+1)'(2 ** ETA_W) - {1'b0, deta};
      end else begin
         abs_deta = {1'b0, deta};
      end
      if (dphi[PHI_W-1]) begin
         abs_dphi = (PHI_W+1)'(2 ** PHI_W) - {1'b0, dphi};
      end else begin
         abs_dphi = {1'b0, dphi};
      end
   end

   // clip pt to the sum range
   always_comb begin
      pt_ext = EXT_W'(track.pt);
      if (pt_ext > EXT_W'({SUM_W{1'b1}})) begin
         pt_sat = {SUM_W{1'b1}};
      end else begin
         pt_sat = SUM_W'(pt_ext);
      end
   end

   // gate the track by the cone and the pt floor
   always_comb begin
      in_cone = (abs_deta < {1'b0, cfg.eta_window}) &&
                (abs_dphi < {1'b0, cfg.phi_window}) &&
                (abs_deta > (ETA_W+1)'(DIFF_FLOOR)) &&
                (abs_dphi > (PHI_W+1)'(DIFF_FLOOR)) &&
                (track.pt > cfg.track_pt_min);
      lane_pt_in = in_cone ? pt_sat : '0;
   end

   // hold the lane result until the merge takes it
   always_ff @(posedge clock) begin
      if (load) begin
         lane_pt_ff <= lane_pt_in;
      end
   end

   assign lane_pt = lane_pt_ff;

endmodule
`default_nettype wire

// ----- src/tci_merge.sv -----
`default_nettype none
module tci_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tci_pkg::stage_type        stage,
   input  wire logic [tci_pkg::SUM_W-1:0] lane_pt [tci_pkg::LANES],
   input  wire logic [tci_pkg::SUM_W-1:0] iso_threshold,
   input  wire logic                      rsp_ready,
   output logic                           advance,
   output logic                           rsp_valid,
   output logic                           rsp_isolated
);
   import tci_pkg::*;

   localparam int TOT_W = SUM_W + $clog2(LANES + 1);

   logic [TOT_W-1:0] total;
   logic [SUM_W-1:0] sum_sat;
   logic [SUM_W-1:0] sum_ff;
   logic             rsp_valid_ff;
   logic             isolated_ff;

   // add the lanes to the running sum and saturate
   always_comb begin
      total = TOT_W'(sum_ff);
      for (int i = 0; i < LANES; i++) begin
         total = total + TOT_W'(lane_pt[i]);
      end
      if (total > TOT_W'({SUM_W{1'b1}})) begin
         sum_sat = {SUM_W{1'b1}};
      end else begin
         sum_sat = SUM_W'(total);
      end
   end

   // a closing transaction waits for a free result slot
   assign advance = stage.valid && (!stage.last || !rsp_valid_ff || rsp_ready);

   // accumulate, and close the event on its last transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (advance && stage.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (stage.last) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_sat;
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && stage.last) begin
         isolated_ff <= (sum_sat < iso_threshold);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_isolated = isolated_ff;

endmodule
`default_nettype wire
